// ===== rtl/core/wfg_pkg.sv =====
// Shared types and constants for the waveform function generator.
package wfg_pkg;

    // Register indexes on the configuration channel
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 3'd4;

    // Waveform select codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

    // Field widths
    localparam int WAVE_W     = 17;   // signed Q1.15 plus room for +1.0
    localparam int LEVEL_W    = 15;   // signed millivolts
    localparam int SCALE_W    = 8;    // amplitude / offset in 25 mV steps
    localparam int PRESCALE_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    // Output data bit positions
    localparam int M_DIG_BIT = LEVEL_W;
    localparam int M_CHG_BIT = LEVEL_W + 1;

    // Millivolts per amplitude / offset step
    localparam logic [4:0] MV_PER_STEP = 5'd25;

endpackage

// ===== rtl/core/wfg_wave.sv =====
// Waveform shaper: phase word to a signed Q1.15 wave sample.
module wfg_wave
    import wfg_pkg::*;
#(
    parameter int PHASE_BITS         = 32,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic [PHASE_BITS-1:0]   i_phase,
    input  logic [1:0]              i_waveform,
    output logic signed [WAVE_W-1:0] o_wave
);

    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int QTR_W = PHASE_BITS - 2;
    localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
    localparam logic [IDX_W-1:0] N_IDX = IDX_W'(SINE_TABLE_ENTRIES);

    typedef logic [14:0] t_sine_rom [SINE_TABLE_ENTRIES+1];

    // Quarter-wave table, Taylor series in Q30 evaluated at elaboration
    function automatic t_sine_rom build_rom();
        t_sine_rom   rom;
        logic [63:0] step61;
        logic [63:0] x30;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        logic signed [63:0] sum;
        step61 = HALF_PI_Q61 / SINE_TABLE_ENTRIES;
        for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
            x30  = (step61 * 64'(i)) >> 31;
            x2   = (x30 * x30) >> 30;
            term = x30;
            sum  = $signed(x30);
            for (int k = 1; k < 14; k++) begin
                term = (term * x2) >> 30;
                case (k)
                    1:  term = term / 6;
                    2:  term = term / 20;
                    3:  term = term / 42;
                    4:  term = term / 72;
                    5:  term = term / 110;
                    6:  term = term / 156;
                    7:  term = term / 210;
                    8:  term = term / 272;
                    9:  term = term / 342;
                    10: term = term / 420;
                    11: term = term / 506;
                    12: term = term / 600;
                    default: term = term / 702;
                endcase
                if (k % 2 == 1) sum = sum - $signed(term);
                else            sum = sum + $signed(term);
            end
            if (sum < 0) sum = '0;
            v = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767) v = 64'd32767;
            rom[i] = v[14:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    logic [1:0]             quad;
    logic [QTR_W-1:0]       quad_pos;
    logic [QTR_W+IDX_W-1:0] scaled;
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       idx_m;
    logic [14:0]            sine_mag;
    logic signed [WAVE_W-1:0] sine_w;
    logic signed [WAVE_W-1:0] square_w;
    logic signed [WAVE_W-1:0] tri_w;
    logic [PHASE_BITS+16:0] ph_ext;
    logic [16:0]            tri_u;
    logic signed [17:0]     tri_s;

    // Sine: quadrant from top bits, table index from the remainder
    assign quad     = i_phase[PHASE_BITS-1:PHASE_BITS-2];
    assign quad_pos = i_phase[QTR_W-1:0];
    assign scaled   = (QTR_W+IDX_W)'(quad_pos) * (QTR_W+IDX_W)'(SINE_TABLE_ENTRIES);
    assign idx      = scaled[QTR_W+IDX_W-1:QTR_W];
    assign idx_m    = quad[0] ? (N_IDX - idx) : idx;
    assign sine_mag = SINE_ROM[idx_m];
    assign sine_w   = quad[1] ? -$signed({2'b00, sine_mag}) : $signed({2'b00, sine_mag});

    // Square: high only strictly inside the first half cycle
    assign square_w = (!i_phase[PHASE_BITS-1] && (i_phase != '0)) ?
                      17'sd32768 : -17'sd32768;

    // Triangle on the top 17 phase bits
    assign ph_ext = {i_phase, 17'b0};
    assign tri_u  = ph_ext[PHASE_BITS+16:PHASE_BITS];
    always_comb begin
        if (tri_u < 17'd32768)
            tri_s = -$signed({1'b0, tri_u});
        else if (tri_u < 17'd98304)
            tri_s = $signed({1'b0, tri_u}) - 18'sd65536;
        else
            tri_s = 18'sd131072 - $signed({1'b0, tri_u});
    end
    assign tri_w = tri_s[WAVE_W-1:0];

    always_comb begin
        case (i_waveform)
            WAVE_SINE:     o_wave = sine_w;
            WAVE_SQUARE:   o_wave = square_w;
            WAVE_TRIANGLE: o_wave = tri_w;
            default:       o_wave = '0;
        endcase
    end

endmodule

// ===== rtl/core/waveform_function_generator.sv =====
// Top level of the prescaled DDS function generator (sine, square, triangle).
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata[0] tick
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata level_mv, digital_level, changed
//  cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One tick transaction is taken every cycle while s_axis_tready is high.
// A tick that emits a sample reaches m_axis through the phase-to-wave stage,
// then the amplitude multiply and offset add into the output register.
// Synchronous active-low reset clears settings to defaults and empties the
// pipeline; the first tick after reset emits a sample.
// A stalled m_axis holds its result; the wave stage still fills behind it,
// and s_axis_tready drops only when both stages are full.
module waveform_function_generator
    import wfg_pkg::*;
#(
    parameter int PHASE_BITS         = 32,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tick transactions
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [0] tick, [7:1] zero
    // sample transactions
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [14:0] level_mv, [15] digital_level,
                                                  // [16] digital_changed, [23:17] zero
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // settings
    logic [1:0]            r_waveform;
    logic [SCALE_W-1:0]    r_amplitude;
    logic [SCALE_W-1:0]    r_offset;
    logic [PHASE_BITS-1:0] r_phase_step;
    logic [PRESCALE_W-1:0] r_prescale;

    // generator state
    logic [PRESCALE_W-1:0] r_tick_count, n_tick_count;
    logic [PHASE_BITS-1:0] r_phase, n_phase;

    // wave stage
    logic                     r_s1_valid;
    logic signed [WAVE_W-1:0] r_s1_wave;
    logic [SCALE_W-1:0]       r_s1_amp;
    logic [SCALE_W-1:0]       r_s1_offset;

    // output stage
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level;
    logic               r_dig;
    logic               r_chg;
    logic               r_last_known;
    logic               r_last_dig;

    logic                     s_accept;
    logic                     cfg_we;
    logic                     sample;
    logic                     out_load;
    logic [PRESCALE_W-1:0]    period;
    logic signed [WAVE_W-1:0] wave;
    logic [CFG_DATA_W+PHASE_BITS-1:0] step_ext;
    logic [PRESCALE_W-1:0]    cfg_period;

    // multiply / offset path
    logic [12:0]          amp_mv;
    logic [12:0]          offs_mv;
    logic signed [13:0]   amp_s;
    logic signed [30:0]   prod;
    logic signed [30:0]   biased;
    logic signed [14:0]   rounded;
    logic signed [15:0]   level_sum;
    logic                 dig;

    assign o_cfg_ready   = 1'b1;
    assign cfg_we        = i_cfg_valid;
    assign out_load      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_load;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign period     = (r_prescale == '0) ? PRESCALE_W'(1) : r_prescale;
    assign cfg_period = i_cfg_data[PRESCALE_W-1:0];
    assign step_ext   = {{PHASE_BITS{1'b0}}, i_cfg_data};

    // Prescaler and phase accumulator
    always_comb begin
        n_tick_count = r_tick_count;
        n_phase      = r_phase;
        sample       = 1'b0;
        if (s_accept && s_axis_tdata[0]) begin
            if (({1'b0, r_tick_count} + 17'd1) < {1'b0, period}) begin
                n_tick_count = r_tick_count + PRESCALE_W'(1);
            end else begin
                n_tick_count = '0;
                sample       = 1'b1;
                n_phase      = r_phase + r_phase_step;
            end
        end
        // a period write preloads the count so the next tick fires
        if (cfg_we && (i_cfg_index == CFG_PRESCALE)) begin
            n_tick_count = (cfg_period == '0) ? '0 : cfg_period - PRESCALE_W'(1);
        end
    end

    wfg_wave #(
        .PHASE_BITS         (PHASE_BITS),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_wave (
        .i_phase    (r_phase),
        .i_waveform (r_waveform),
        .o_wave     (wave)
    );

    // level = round(wave * amp * 25 / 32768) + offset * 25
    assign amp_mv    = 13'(r_s1_amp) * 13'(MV_PER_STEP);
    assign offs_mv   = 13'(r_s1_offset) * 13'(MV_PER_STEP);
    assign amp_s     = $signed({1'b0, amp_mv});
    assign prod      = r_s1_wave * amp_s;
    assign biased    = prod + 31'sd16384;
    assign rounded   = biased[29:15];
    assign level_sum = {rounded[14], rounded} + $signed({3'b000, offs_mv});
    assign dig       = (rounded > 15'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform   <= WAVE_SINE;
            r_amplitude  <= '0;
            r_offset     <= '0;
            r_phase_step <= '0;
            r_prescale   <= PRESCALE_W'(1);
            r_tick_count <= '0;
            r_phase      <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_known <= 1'b0;
            r_last_dig   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_WAVEFORM:  r_waveform   <= i_cfg_data[1:0];
                    CFG_AMPLITUDE: r_amplitude  <= i_cfg_data[SCALE_W-1:0];
                    CFG_OFFSET:    r_offset     <= i_cfg_data[SCALE_W-1:0];
                    CFG_STEP:      r_phase_step <= step_ext[PHASE_BITS-1:0];
                    CFG_PRESCALE:  r_prescale   <= cfg_period;
                    default: ;
                endcase
            end
            r_tick_count <= n_tick_count;
            r_phase      <= n_phase;

            if (s_axis_tready) r_s1_valid <= sample;
            if (out_load) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_last_known <= 1'b1;
                    r_last_dig   <= dig;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (sample) begin
            r_s1_wave   <= wave;
            r_s1_amp    <= r_amplitude;
            r_s1_offset <= r_offset;
        end
        if (out_load && r_s1_valid) begin
            r_level <= level_sum[LEVEL_W-1:0];
            r_dig   <= dig;
            r_chg   <= !r_last_known || (dig != r_last_dig);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-LEVEL_W-2){1'b0}}, r_chg, r_dig, r_level};

endmodule

// ===== rtl/core/wfg_checker.sv =====
// Port-level checks for the waveform function generator, bound to the top.
module wfg_checker
    import wfg_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [S_TDATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_offset_seen;
    logic [SCALE_W-1:0] r_offset;
    logic               r_known;
    logic               r_last_dig;
    logic               m_xfer;
    logic signed [15:0] level;
    logic signed [15:0] offs_mv;

    assign m_xfer  = m_axis_tvalid && m_axis_tready;
    assign level   = {m_axis_tdata[LEVEL_W-1], m_axis_tdata[LEVEL_W-1:0]};
    assign offs_mv = $signed({3'b000, 13'(r_offset) * 13'(MV_PER_STEP)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_seen <= 1'b1;
            r_offset      <= '0;
            r_known       <= 1'b0;
            r_last_dig    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_OFFSET))
                r_offset <= i_cfg_data[SCALE_W-1:0];
            if (m_xfer) begin
                r_known    <= 1'b1;
                r_last_dig <= m_axis_tdata[M_DIG_BIT];
            end
        end
    end

    // held result under backpressure
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a fresh result needs an accepted tick that passed the wave and output stages
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tdata[0], 2))
        else $error("result without a tick");

    // change flag follows the delivered digital level
    a_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_xfer |-> (m_axis_tdata[M_CHG_BIT] ==
                    (!r_known || (m_axis_tdata[M_DIG_BIT] != r_last_dig))))
        else $error("digital_changed mismatch");

    // digital level means the analog level sits above the offset
    a_digital: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_xfer && r_offset_seen |-> (m_axis_tdata[M_DIG_BIT] == (level > offs_mv)))
        else $error("digital_level does not match level");

endmodule

bind waveform_function_generator wfg_checker u_wfg_checker (.*);
